/* rtl/longest_prefix_match_router_assert.svh */
// Assertion macros shared by the route table checker.
`ifndef LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_ROUTER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lpm_pkg.sv */
// Types, codes and helper functions of the longest prefix match route table.
`timescale 1ns / 1ps

package lpm_pkg;

  localparam int LpmMaxIfaces = 16;
  localparam int LpmLimW      = 9;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_BAD_IFACE = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_FORWARDED = 3'd4;
  localparam logic [2:0] ST_TTL_DROP  = 3'd5;
  localparam logic [2:0] ST_NO_ROUTE  = 3'd6;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        has_hop;
    logic [31:0] hop;
    logic [3:0]  iface;
  } lpm_entry_t;

  typedef struct packed {
    logic [31:0] dst;
    logic [7:0]  ttl;
    logic        found;
    logic [5:0]  len;
    logic [3:0]  iface;
    logic [31:0] hop;
  } lpm_pkt_t;

  function automatic logic [31:0] lpm_mask(input logic [5:0] len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

endpackage

/* rtl/lpm_cell.sv */
// One route table cell: holds one route and updates the passing lookup.
`timescale 1ns / 1ps

module lpm_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  lpm_pkg::lpm_entry_t wr_entry_i,
  input  logic              active_i,
  input  logic              vld_i,
  input  lpm_pkg::lpm_pkt_t pkt_i,
  output logic              vld_o,
  output lpm_pkg::lpm_pkt_t pkt_o
);
  import lpm_pkg::*;

  lpm_entry_t entry_q;
  lpm_pkt_t   pkt_d, pkt_q;
  logic       vld_q;
  logic       hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_entry_i;
    end
  end

  always_comb begin
    hit = active_i && ((pkt_i.dst & lpm_mask(entry_q.len)) == entry_q.prefix) &&
          (!pkt_i.found || (entry_q.len > pkt_i.len));
    pkt_d = pkt_i;
    if (hit) begin
      pkt_d.found = 1'b1;
      pkt_d.len   = entry_q.len;
      pkt_d.iface = entry_q.iface;
      pkt_d.hop   = entry_q.has_hop ? entry_q.hop : pkt_i.dst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      pkt_q <= pkt_d;
    end
  end

  assign vld_o = vld_q;
  assign pkt_o = pkt_q;

endmodule

/* rtl/longest_prefix_match_router.sv */
// Top level of the IPv4 longest prefix match route table.
// Routes live in a row of MAX_ROUTES cells, one route per cell, filled in
// order. An add request or a TTL drop gives its result in the cycle after the
// input transfer. A forward lookup walks down the row one cell per cycle,
// so its result passes every cell register and then the output register
// whatever the number of stored routes. One request is in progress at a
// time: the input is ready again once no lookup is in the row and the
// output register is empty or being emptied in the same cycle.
`timescale 1ns / 1ps

module longest_prefix_match_router #(
  parameter int MAX_ROUTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [31:0] route_prefix_i,
  input  logic [5:0]  prefix_len_i,
  input  logic        has_next_hop_i,
  input  logic [31:0] next_hop_addr_i,
  input  logic [3:0]  out_interface_i,
  input  logic [31:0] dst_addr_i,
  input  logic [7:0]  packet_ttl_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [3:0]  send_interface_o,
  output logic [31:0] send_next_hop_o,
  output logic [7:0]  new_ttl_o
);
  import lpm_pkg::*;

  localparam int CntW = $clog2(MAX_ROUTES + 1);

  logic [4:0]         num_if_q;
  logic [CntW-1:0]    route_cnt_q;
  logic               busy_q;
  logic               out_valid_q;
  logic [2:0]         status_q;
  logic [3:0]         iface_q;
  logic [31:0]        hop_q;
  logic [7:0]         ttl_q;

  logic               accept;
  logic [LpmLimW-1:0] if_limit;
  logic               bad_len, bad_iface, full, add_ok, ttl_drop, launch, done;
  logic               direct_load;
  logic [2:0]         direct_status;
  lpm_entry_t         new_entry;

  logic               vld_chain [MAX_ROUTES+1];
  lpm_pkt_t           pkt_chain [MAX_ROUTES+1];

  assign in_ready_o = !busy_q && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign if_limit  = (num_if_q > LpmLimW'(LpmMaxIfaces)) ? LpmLimW'(LpmMaxIfaces)
                                                          : LpmLimW'(num_if_q);
  assign bad_len   = prefix_len_i > 6'd32;
  assign bad_iface = LpmLimW'(out_interface_i) >= if_limit;
  assign full      = route_cnt_q == CntW'(MAX_ROUTES);
  assign add_ok    = accept && !req_type_i && !bad_len && !bad_iface && !full;
  assign ttl_drop  = packet_ttl_i <= 8'd1;
  assign launch    = accept && req_type_i && !ttl_drop;
  assign done      = vld_chain[MAX_ROUTES];
  assign direct_load = accept && !launch;

  always_comb begin
    if (req_type_i) begin
      direct_status = ST_TTL_DROP;
    end else if (bad_len) begin
      direct_status = ST_BAD_LEN;
    end else if (bad_iface) begin
      direct_status = ST_BAD_IFACE;
    end else if (full) begin
      direct_status = ST_FULL;
    end else begin
      direct_status = ST_ADDED;
    end
  end

  always_comb begin
    new_entry.prefix  = route_prefix_i & lpm_mask(prefix_len_i);
    new_entry.len     = prefix_len_i;
    new_entry.has_hop = has_next_hop_i;
    new_entry.hop     = next_hop_addr_i;
    new_entry.iface   = out_interface_i;
  end

  always_comb begin
    vld_chain[0]       = launch;
    pkt_chain[0].dst   = dst_addr_i;
    pkt_chain[0].ttl   = packet_ttl_i;
    pkt_chain[0].found = 1'b0;
    pkt_chain[0].len   = 6'd0;
    pkt_chain[0].iface = 4'd0;
    pkt_chain[0].hop   = 32'd0;
  end

  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    lpm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (add_ok && (route_cnt_q == CntW'(i))),
      .wr_entry_i (new_entry),
      .active_i   (route_cnt_q > CntW'(i)),
      .vld_i      (vld_chain[i]),
      .pkt_i      (pkt_chain[i]),
      .vld_o      (vld_chain[i+1]),
      .pkt_o      (pkt_chain[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_if_q    <= 5'd4;
      route_cnt_q <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_if_q <= cfg_wdata_i;
      end
      if (add_ok) begin
        route_cnt_q <= route_cnt_q + 1'b1;
      end
      if (launch) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (direct_load || done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (direct_load) begin
      status_q <= direct_status;
      iface_q  <= 4'd0;
      hop_q    <= 32'd0;
      ttl_q    <= 8'd0;
    end else if (done) begin
      if (pkt_chain[MAX_ROUTES].found) begin
        status_q <= ST_FORWARDED;
        iface_q  <= pkt_chain[MAX_ROUTES].iface;
        hop_q    <= pkt_chain[MAX_ROUTES].hop;
        ttl_q    <= pkt_chain[MAX_ROUTES].ttl - 8'd1;
      end else begin
        status_q <= ST_NO_ROUTE;
        iface_q  <= 4'd0;
        hop_q    <= 32'd0;
        ttl_q    <= 8'd0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign send_interface_o = iface_q;
  assign send_next_hop_o  = hop_q;
  assign new_ttl_o        = ttl_q;

endmodule

/* rtl/lpm_checker.sv */
// Port-level checker for the route table, bound to its top level.
`timescale 1ns / 1ps
`include "longest_prefix_match_router_assert.svh"

module lpm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [3:0]  send_interface_o,
  input logic [31:0] send_next_hop_o,
  input logic [7:0]  new_ttl_o
);
  import lpm_pkg::*;

  // A transfer either produces a result at once or keeps the input closed.
  `LPM_ASSERT_NEXT(a_accept_then_busy, in_valid_i && in_ready_o, out_valid_o || !in_ready_o, "input open with no result after a transfer")
  // No new request is taken while a result waits downstream.
  `LPM_ASSERT_NOW(a_no_accept_on_stall, out_valid_o && !out_ready_i, !in_ready_o, "input accepted while the result is stalled")
  // A forwarded datagram always leaves with a live TTL.
  `LPM_ASSERT_NOW(a_fwd_ttl, out_valid_o && (status_o == ST_FORWARDED), new_ttl_o != 8'd0, "forwarded datagram with zero TTL")
  // Every other result carries zeroed forwarding fields.
  `LPM_ASSERT_NOW(a_other_zero, out_valid_o && (status_o != ST_FORWARDED), (send_interface_o == 4'd0) && (send_next_hop_o == 32'd0) && (new_ttl_o == 8'd0), "nonzero fields on a result that was not forwarded")
  // A stalled result holds its status.
  `LPM_ASSERT_NEXT(a_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o), "stalled result changed")

endmodule

bind longest_prefix_match_router lpm_checker u_lpm_checker (.*);

/* sim/tb_top.sv */
// Self-checking testbench for the longest prefix match route table.
`timescale 1ns / 1ps

module tb_top;
  import lpm_pkg::*;

  localparam int MaxRoutes     = 64;
  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 400;
  localparam bit REQ_ADD       = 1'b0;
  localparam bit REQ_FORWARD   = 1'b1;

  typedef struct {
    bit        req;
    bit [31:0] prefix;
    bit [5:0]  len;
    bit        has_hop;
    bit [31:0] hop;
    bit [3:0]  iface;
    bit [31:0] dst;
    bit [7:0]  ttl;
  } request_t;

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  iface;
    logic [31:0] hop;
    logic [7:0]  ttl;
  } reply_t;

  typedef struct {
    bit [31:0] prefix;
    bit [5:0]  len;
    bit        has_hop;
    bit [31:0] hop;
    bit [3:0]  iface;
  } route_t;

  class route_scoreboard;
    route_t      routes[MaxRoutes];
    int unsigned route_cnt;
    bit [4:0]    iface_reg;
    reply_t      pending_replies[$];
    int unsigned errors;

    function new();
      route_cnt = 0;
      iface_reg = 5'd4;
      errors = 0;
    endfunction

    function bit [31:0] len_mask(bit [5:0] len);
      if (len == 0) return 32'h0;
      return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function int unsigned iface_limit();
      return (iface_reg > 16) ? 16 : iface_reg;
    endfunction

    function void note_request(request_t r);
      reply_t exp;
      int     best;
      exp = '{ST_ADDED, 4'h0, 32'h0, 8'h0};
      if (r.req == REQ_ADD) begin
        if (r.len > 32) begin
          exp.status = ST_BAD_LEN;
        end else if (r.iface >= iface_limit()) begin
          exp.status = ST_BAD_IFACE;
        end else if (route_cnt >= MaxRoutes) begin
          exp.status = ST_FULL;
        end else begin
          routes[route_cnt] = '{r.prefix & len_mask(r.len), r.len, r.has_hop, r.hop, r.iface};
          route_cnt++;
        end
      end else if (r.ttl <= 1) begin
        exp.status = ST_TTL_DROP;
      end else begin
        best = -1;
        for (int i = 0; i < route_cnt; i++) begin
          if ((r.dst & len_mask(routes[i].len)) == routes[i].prefix &&
              (best < 0 || routes[i].len > routes[best].len)) begin
            best = i;
          end
        end
        if (best < 0) begin
          exp.status = ST_NO_ROUTE;
        end else begin
          exp.status = ST_FORWARDED;
          exp.iface  = routes[best].iface;
          exp.hop    = routes[best].has_hop ? routes[best].hop : r.dst;
          exp.ttl    = r.ttl - 8'd1;
        end
      end
      pending_replies.insert(pending_replies.size(), exp);
    endfunction

    function void compare(string field, logic [31:0] exp, logic [31:0] got);
      if (got !== exp) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t exp;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %h", $time, got.status);
        errors++;
        return;
      end
      exp = pending_replies.pop_front();
      compare("status", exp.status, got.status);
      compare("send_interface", exp.iface, got.iface);
      compare("send_next_hop", exp.hop, got.hop);
      compare("new_ttl", exp.ttl, got.ttl);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = 5'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        req_type_i = 1'b0;
  logic [31:0] route_prefix_i = 32'h0;
  logic [5:0]  prefix_len_i = 6'd0;
  logic        has_next_hop_i = 1'b0;
  logic [31:0] next_hop_addr_i = 32'h0;
  logic [3:0]  out_interface_i = 4'd0;
  logic [31:0] dst_addr_i = 32'h0;
  logic [7:0]  packet_ttl_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [3:0]  send_interface_o;
  logic [31:0] send_next_hop_o;
  logic [7:0]  new_ttl_o;

  route_scoreboard board = new();
  int unsigned     send_idle_pct = 6;
  int unsigned     recv_idle_pct = 65;
  bit              hold_req = 1'b0;
  int unsigned     hold_left = 0;
  int unsigned     quiet_cycles = 0;

  longest_prefix_match_router #(
    .MAX_ROUTES(MaxRoutes)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .route_prefix_i  (route_prefix_i),
    .prefix_len_i    (prefix_len_i),
    .has_next_hop_i  (has_next_hop_i),
    .next_hop_addr_i (next_hop_addr_i),
    .out_interface_i (out_interface_i),
    .dst_addr_i      (dst_addr_i),
    .packet_ttl_i    (packet_ttl_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .send_interface_o(send_interface_o),
    .send_next_hop_o (send_next_hop_o),
    .new_ttl_o       (new_ttl_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic request_t build_request(bit req, bit [31:0] prefix, bit [5:0] len,
                                             bit has_hop, bit [31:0] hop, bit [3:0] iface,
                                             bit [31:0] dst, bit [7:0] ttl);
    request_t r;
    r = '{req, prefix, len, has_hop, hop, iface, dst, ttl};
    return r;
  endfunction

  function automatic request_t make_request();
    request_t    r;
    route_t      base;
    int unsigned limit;
    r = '{1'($urandom_range(1)), $urandom, 6'($urandom_range(63)), 1'($urandom_range(1)),
          $urandom, 4'($urandom_range(15)), $urandom, 8'($urandom_range(255))};
    limit = board.iface_limit();
    if ($urandom_range(99) < 30) begin
      r.req = REQ_ADD;
      if ($urandom_range(99) < 88) r.len = 6'($urandom_range(32));
      if (limit > 0 && $urandom_range(99) < 85) r.iface = 4'($urandom_range(limit - 1));
      if (board.route_cnt > 0 && $urandom_range(1) == 1) begin
        base = board.routes[$urandom_range(board.route_cnt - 1)];
        if (r.len <= 32) r.len = 6'($urandom_range(32, base.len));
        r.prefix = base.prefix | (r.prefix & ~board.len_mask(base.len));
      end
    end else begin
      r.req = REQ_FORWARD;
      if ($urandom_range(99) < 10) r.ttl = 8'($urandom_range(1));
      if (board.route_cnt > 0 && $urandom_range(99) < 80) begin
        base = board.routes[$urandom_range(board.route_cnt - 1)];
        r.dst = base.prefix | (r.dst & ~board.len_mask(base.len));
      end
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= r.req;
    route_prefix_i  <= r.prefix;
    prefix_len_i    <= r.len;
    has_next_hop_i  <= r.has_hop;
    next_hop_addr_i <= r.hop;
    out_interface_i <= r.iface;
    dst_addr_i      <= r.dst;
    packet_ttl_i    <= r.ttl;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(r);
  endtask

  task automatic drain_and_configure(bit [4:0] value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_replies.size() != 0);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.iface_reg = value;
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        board.check_reply('{status_o, send_interface_o, send_next_hop_o, new_ttl_o});
      end
      if (hold_req) begin
        hold_left = HoldOffCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    drain_and_configure(5'd4);
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'h0A00_0001, 8'd64));
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 8'd0));
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'hC0A8_0101, 8'd1));
    send_request(build_request(REQ_ADD, 32'hC0A8_0101, 6'd33, 1, 32'h0A00_0001, 4'd0, 0, 0));
    send_request(build_request(REQ_ADD, 32'hFFFF_FFFF, 6'd63, 1, 32'hFFFF_FFFF, 4'd15, 0, 0));
    send_request(build_request(REQ_ADD, 32'h0A00_0000, 6'd8, 0, 32'h0, 4'd4, 0, 0));
    send_request(build_request(REQ_ADD, 32'hFFFF_FFFF, 6'd0, 0, 32'hDEAD_BEEF, 4'd3, 0, 0));
    send_request(build_request(REQ_ADD, 32'hC0A8_0101, 6'd32, 1, 32'h0A00_00FE, 4'd1, 0, 0));
    send_request(build_request(REQ_ADD, 32'hC0A8_01FF, 6'd24, 1, 32'h0A00_0002, 4'd2, 0, 0));
    send_request(build_request(REQ_ADD, 32'hC0A8_0100, 6'd24, 1, 32'h0A00_0003, 4'd0, 0, 0));
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'hC0A8_0101, 8'd255));
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'hC0A8_0177, 8'd2));
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'h0A00_0001, 8'd100));
    drain_and_configure(5'd0);
    send_request(build_request(REQ_ADD, 32'h0A00_0000, 6'd8, 1, 32'h0101_0101, 4'd0, 0, 0));
    drain_and_configure(5'd31);
    send_request(build_request(REQ_ADD, 32'h0A00_0000, 6'd8, 1, 32'h0101_0101, 4'd15, 0, 0));
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'h0A0A_0A0A, 8'd128));
    drain_and_configure(5'd1);
    send_request(build_request(REQ_ADD, 32'h0A0B_0000, 6'd16, 0, 32'h0, 4'd1, 0, 0));
    send_request(build_request(REQ_ADD, 32'h0A0B_0000, 6'd16, 0, 32'h0, 4'd0, 0, 0));
    send_request(build_request(REQ_FORWARD, 0, 0, 0, 0, 0, 32'h0A0B_0C0D, 8'd3));

    drain_and_configure(5'd16);
    for (int n = 0; n < 180; n++) send_request(make_request());

    drain_and_configure(5'd9);
    send_idle_pct = 65;
    recv_idle_pct = 6;
    for (int n = 0; n < 180; n++) send_request(make_request());

    drain_and_configure(5'd31);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int n = 0; n < 190; n++) send_request(make_request());

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending_replies.size() != 0);
    repeat (MaxRoutes + 16) @(posedge clk_i);
    if (board.errors == 0 && board.pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/lpm_pkg.sv
rtl/lpm_cell.sv
rtl/longest_prefix_match_router.sv
rtl/lpm_checker.sv
sim/tb_top.sv
